@@ hw/rtl/ipv4hb_pkg.sv @@
// ----------------------------------------------------------------------------
// ipv4hb_pkg
// Shared types, constants and the byte-selection function of the IPv4 header
// builder.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv4hb_pkg;

  localparam int HdrBytes = 20;
  localparam int PosW     = 5;
  localparam int SumW     = 19;   // seven 16-bit terms fit in 19 bits
  localparam int QDepth   = 2;
  localparam int QAddrW   = 1;
  localparam int QCountW  = 2;

  localparam logic [PosW-1:0] LastPos    = 5'd19;
  localparam logic [15:0]     HdrLenBias = 16'd20;
  localparam logic [7:0]      VerIhl     = 8'h45;
  localparam logic [7:0]      FlagsDf    = 8'h40;
  // Constant header words 0x4500 and 0x4000 folded into one term.
  localparam logic [15:0]     ConstWords = 16'h8500;

  // Byte positions within the header.
  localparam logic [PosW-1:0] PosVerIhl = 5'd0;
  localparam logic [PosW-1:0] PosTos    = 5'd1;
  localparam logic [PosW-1:0] PosLenHi  = 5'd2;
  localparam logic [PosW-1:0] PosLenLo  = 5'd3;
  localparam logic [PosW-1:0] PosIdHi   = 5'd4;
  localparam logic [PosW-1:0] PosIdLo   = 5'd5;
  localparam logic [PosW-1:0] PosFlags  = 5'd6;
  localparam logic [PosW-1:0] PosFrag   = 5'd7;
  localparam logic [PosW-1:0] PosTtl    = 5'd8;
  localparam logic [PosW-1:0] PosProto  = 5'd9;
  localparam logic [PosW-1:0] PosCksHi  = 5'd10;
  localparam logic [PosW-1:0] PosCksLo  = 5'd11;
  localparam logic [PosW-1:0] PosSrc0   = 5'd12;
  localparam logic [PosW-1:0] PosSrc1   = 5'd13;
  localparam logic [PosW-1:0] PosSrc2   = 5'd14;
  localparam logic [PosW-1:0] PosSrc3   = 5'd15;
  localparam logic [PosW-1:0] PosDst0   = 5'd16;
  localparam logic [PosW-1:0] PosDst1   = 5'd17;
  localparam logic [PosW-1:0] PosDst2   = 5'd18;
  localparam logic [PosW-1:0] PosDst3   = 5'd19;

  typedef struct packed {
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [7:0]  protocol_number;
    logic [7:0]  time_to_live;
    logic [15:0] payload_length;
  } req_t;

  typedef struct packed {
    logic [7:0]      header_byte;
    logic [PosW-1:0] byte_position;
    logic            last_byte;
  } rsp_t;

  // Everything the serializer needs to emit one header.
  typedef struct packed {
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [7:0]  protocol_number;
    logic [7:0]  time_to_live;
    logic [15:0] total_length;
    logic [15:0] checksum;
  } hdr_t;

  function automatic logic [7:0] hdr_byte(input hdr_t h, input logic [PosW-1:0] pos);
    logic [7:0] b;
    b = 8'h00;
    unique case (pos)
      PosVerIhl: b = VerIhl;
      PosLenHi:  b = h.total_length[15:8];
      PosLenLo:  b = h.total_length[7:0];
      PosFlags:  b = FlagsDf;
      PosTtl:    b = h.time_to_live;
      PosProto:  b = h.protocol_number;
      PosCksHi:  b = h.checksum[15:8];
      PosCksLo:  b = h.checksum[7:0];
      PosSrc0:   b = h.source_address[31:24];
      PosSrc1:   b = h.source_address[23:16];
      PosSrc2:   b = h.source_address[15:8];
      PosSrc3:   b = h.source_address[7:0];
      PosDst0:   b = h.destination_address[31:24];
      PosDst1:   b = h.destination_address[23:16];
      PosDst2:   b = h.destination_address[15:8];
      PosDst3:   b = h.destination_address[7:0];
      PosTos, PosIdHi, PosIdLo, PosFrag: b = 8'h00;
      default:   b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ipv4hb_front.sv @@
// ----------------------------------------------------------------------------
// ipv4hb_front
// Accepts requests and computes total length and header checksum in a
// two-stage pipeline that stalls when the header queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4hb_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ipv4hb_pkg::req_t  req,
  input  wire logic              push,
  output logic                   full,
  output ipv4hb_pkg::hdr_t       hdr,
  output logic                   hdr_valid,
  input  wire logic              hdr_ready
);

  ipv4hb_pkg::req_t          s1_req;
  logic                      s1_valid;
  ipv4hb_pkg::req_t          s2_req;
  logic [15:0]               s2_total;
  logic [ipv4hb_pkg::SumW-1:0] s2_sum;
  logic                      s2_valid;

  logic                      s2_ready;
  logic                      s1_move;
  logic [15:0]               total_next;
  logic [ipv4hb_pkg::SumW-1:0] sum_next;
  logic [16:0]               fold1;
  logic [15:0]               fold2;

  assign s2_ready = !s2_valid || hdr_ready;
  assign s1_move  = s1_valid && s2_ready;
  assign full     = s1_valid && !s2_ready;

  // Stage one: total length and the raw sum of the eight nonzero header words.
  always_comb begin
    total_next = s1_req.payload_length + ipv4hb_pkg::HdrLenBias;
    sum_next   = {3'b000, s1_req.source_address[31:16]}
               + {3'b000, s1_req.source_address[15:0]}
               + {3'b000, s1_req.destination_address[31:16]}
               + {3'b000, s1_req.destination_address[15:0]}
               + {3'b000, s1_req.time_to_live, s1_req.protocol_number}
               + {3'b000, total_next}
               + {3'b000, ipv4hb_pkg::ConstWords};
  end

  // Stage two: end-around carry folding and inversion.
  always_comb begin
    fold1 = {1'b0, s2_sum[15:0]} + {14'd0, s2_sum[ipv4hb_pkg::SumW-1:16]};
    fold2 = fold1[15:0] + {15'd0, fold1[16]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (push && !full) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        s2_valid <= 1'b1;
      end else if (hdr_ready) begin
        s2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      s1_req <= req;
    end
    if (s1_move) begin
      s2_req   <= s1_req;
      s2_total <= total_next;
      s2_sum   <= sum_next;
    end
  end

  always_comb begin
    hdr.source_address      = s2_req.source_address;
    hdr.destination_address = s2_req.destination_address;
    hdr.protocol_number     = s2_req.protocol_number;
    hdr.time_to_live        = s2_req.time_to_live;
    hdr.total_length        = s2_total;
    hdr.checksum            = ~fold2;
  end

  assign hdr_valid = s2_valid;

endmodule

`default_nettype wire

@@ hw/rtl/ipv4hb_queue.sv @@
// ----------------------------------------------------------------------------
// ipv4hb_queue
// Short header queue between the checksum pipeline and the serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4hb_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ipv4hb_pkg::hdr_t wr_hdr,
  input  wire logic             wr_valid,
  output logic                  wr_ready,
  output ipv4hb_pkg::hdr_t      rd_hdr,
  output logic                  rd_valid,
  input  wire logic             rd_ready
);

  ipv4hb_pkg::hdr_t                slots [ipv4hb_pkg::QDepth];
  logic [ipv4hb_pkg::QAddrW-1:0]   wr_ptr;
  logic [ipv4hb_pkg::QAddrW-1:0]   rd_ptr;
  logic [ipv4hb_pkg::QCountW-1:0]  count;
  logic                            do_wr;
  logic                            do_rd;

  assign wr_ready = (count != ipv4hb_pkg::QCountW'(ipv4hb_pkg::QDepth));
  assign rd_valid = (count != '0);
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;
  assign rd_hdr   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_hdr;
    end
  end

  // The fill count must never pass the queue depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= ipv4hb_pkg::QCountW'(ipv4hb_pkg::QDepth))
    else $error("header queue count exceeds depth");

  // When the queue is empty or full, the pointers are equal.
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == ipv4hb_pkg::QCountW'(ipv4hb_pkg::QDepth)) |-> (wr_ptr == rd_ptr))
    else $error("header queue pointers disagree with count");

endmodule

`default_nettype wire

@@ hw/rtl/ipv4hb_back.sv @@
// ----------------------------------------------------------------------------
// ipv4hb_back
// Serializer: takes one header from the queue and emits its twenty bytes
// through an output register, one byte per cycle while pop is not held low.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4hb_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ipv4hb_pkg::hdr_t q_hdr,
  input  wire logic             q_valid,
  output logic                  q_ready,
  output ipv4hb_pkg::rsp_t      rsp,
  output logic                  empty,
  input  wire logic             pop
);

  ipv4hb_pkg::hdr_t               cur;
  logic                           cur_valid;
  logic [ipv4hb_pkg::PosW-1:0]    pos;
  ipv4hb_pkg::rsp_t               out;
  logic                           out_valid;

  logic                           out_load;
  logic                           emit;
  logic                           cur_done;

  assign out_load = !out_valid || pop;
  assign emit     = cur_valid && out_load;
  assign cur_done = emit && (pos == ipv4hb_pkg::LastPos);
  assign q_ready  = !cur_valid || cur_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_ready) begin
        cur_valid <= q_valid;
        pos       <= '0;
      end else if (emit) begin
        pos <= pos + 1'b1;
      end
      if (out_load) begin
        out_valid <= cur_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_ready && q_valid) begin
      cur <= q_hdr;
    end
    if (emit) begin
      out.header_byte   <= ipv4hb_pkg::hdr_byte(cur, pos);
      out.byte_position <= pos;
      out.last_byte     <= (pos == ipv4hb_pkg::LastPos);
    end
  end

  assign rsp   = out;
  assign empty = !out_valid;

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (pos <= ipv4hb_pkg::LastPos))
    else $error("byte position past end of header");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out.last_byte == (out.byte_position == ipv4hb_pkg::LastPos)))
    else $error("last byte flag does not match position");

  // A header in flight keeps the serializer one byte ahead of the output.
  a_next_ready: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out.last_byte)
      |-> (cur_valid && (pos == out.byte_position + 1'b1)))
    else $error("serializer lost its place within a header");

endmodule

`default_nettype wire

@@ hw/rtl/ipv4_header_builder_unit.sv @@
// ----------------------------------------------------------------------------
// ipv4_header_builder_unit
// Builds a 20-byte IPv4 header with checksum for each request word and
// streams it out one byte per word.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter as one word on req; a word is taken at a clock edge with
//   push high and full low. Each request yields twenty result words on rsp,
//   header bytes in transmission order with their byte position, the last one
//   flagged by last_byte. A result word is valid while empty is low and is
//   consumed at an edge with pop high.
//   Path: a taken request passes the two checksum stages, the queue and the
//   serializer's header and output registers before its first byte is on rsp.
//   Throughput: one result word per cycle while pop stays high, twenty words
//   per request, set by the byte-wide output register of the serializer.
//   The checksum pipeline and a two-entry header queue can hold several
//   requests ahead of the serializer, so push keeps being accepted while an
//   earlier header is still draining.
//   When the receiver holds pop low, the current byte stays on rsp, the
//   serializer halts, the queue fills and then full rises.
//   A synchronous reset empties every stage; no partial header survives.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_header_builder_unit (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ipv4hb_pkg::req_t req,
  input  wire logic             push,
  output logic                  full,
  output ipv4hb_pkg::rsp_t      rsp,
  output logic                  empty,
  input  wire logic             pop
);

  // Front end to queue.
  ipv4hb_pkg::hdr_t front_hdr;
  logic             front_valid;
  logic             front_ready;

  // Queue to serializer.
  ipv4hb_pkg::hdr_t back_hdr;
  logic             back_valid;
  logic             back_ready;

  // The front computes length and checksum for each accepted request.
  ipv4hb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .push      (push),
    .full      (full),
    .hdr       (front_hdr),
    .hdr_valid (front_valid),
    .hdr_ready (front_ready)
  );

  // The queue decouples checksum generation from byte streaming.
  ipv4hb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_hdr   (front_hdr),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .rd_hdr   (back_hdr),
    .rd_valid (back_valid),
    .rd_ready (back_ready)
  );

  // The serializer emits the header bytes through its output register.
  ipv4hb_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_hdr   (back_hdr),
    .q_valid (back_valid),
    .q_ready (back_ready),
    .rsp     (rsp),
    .empty   (empty),
    .pop     (pop)
  );

endmodule

`default_nettype wire
